FILE: rtl/core/prsd_pkg.sv
`default_nettype none

package prsd_pkg;

  localparam logic [1:0] CMD_PAL  = 2'd0;
  localparam logic [1:0] CMD_HDR  = 2'd1;
  localparam logic [1:0] CMD_DATA = 2'd2;

  localparam logic [1:0] MODE_RGB  = 2'd0;
  localparam logic [1:0] MODE_RGBA = 2'd1;
  localparam logic [1:0] MODE_BGRA = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;

  localparam logic [7:0] RUN_BASE = 8'h80;
  localparam logic [7:0] OPAQUE   = 8'hFF;
  localparam logic [7:0] CLEAR    = 8'h00;

  localparam logic [1:0] REG_COLOUR_MODE = 2'd0;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_OPAQUE,
    KIND_CLEAR
  } kind_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  palette_index;
    logic [7:0]  entry_red;
    logic [7:0]  entry_green;
    logic [7:0]  entry_blue;
    logic [11:0] frame_width;
    logic [11:0] frame_height;
    logic [23:0] payload_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic [6:0] repeat_count;
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
    logic [7:0] chan3;
    logic       frame_done;
  } out_item_t;

  // result descriptor between the control stage and the output stage
  typedef struct packed {
    logic       status;
    logic [6:0] repeat_count;
    kind_t      kind;
    logic       frame_done;
  } desc_t;

endpackage

`default_nettype wire

FILE: rtl/core/palette_rle_sprite_decoder.sv
// Palette-indexed run-length sprite decoder. Items (palette writes, frame headers,
// payload bytes) are taken at one per clock while in_stall is low; each result is
// registered in the synchronous palette read, beside the control stage, then in the
// output register. in_stall rises only when both the palette-read stage and the
// output register hold results that the sink has not taken. Frame counters update
// in the accept cycle, so back-to-back bytes of one frame never wait on each other.
// Color order follows the colour_mode register at byte address 0 (0 RGB,
// 1 RGBA, 2 BGRA, 3 ignored); change it only while no results are in flight.
`default_nettype none

module palette_rle_sprite_decoder #(
  parameter int PALETTE_DEPTH = 256,
  parameter int MAX_DIM       = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire prsd_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output prsd_pkg::out_item_t      out_item,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import prsd_pkg::*;

  logic        accept;
  logic        advance;
  logic        desc_valid;
  desc_t       desc;
  logic [23:0] rd_data;
  logic [1:0]  mode_r;
  logic        cfg_wr;

  assign in_stall = desc_valid && !advance;
  assign accept   = in_valid && !in_stall;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && ({1'b0, paddr[2]} == REG_COLOUR_MODE)
                  && (pwdata[1:0] != MODE_RSVD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RGBA;
    end else if (cfg_wr) begin
      mode_r <= pwdata[1:0];
    end
  end

  assign prdata = ({1'b0, paddr[2]} == REG_COLOUR_MODE) ? {30'd0, mode_r} : 32'd0;

  prsd_palette #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept && (in_item.cmd == CMD_PAL)),
    .wr_index(in_item.palette_index),
    .wr_data ({in_item.entry_red, in_item.entry_green, in_item.entry_blue}),
    .rd_en   (accept),
    .rd_index(in_item.data_byte),
    .rd_data (rd_data)
  );

  prsd_ctrl #(
    .MAX_DIM(MAX_DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_item),
    .advance   (advance),
    .desc_valid(desc_valid),
    .desc      (desc)
  );

  prsd_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_valid (desc_valid),
    .desc       (desc),
    .rd_data    (rd_data),
    .colour_mode(mode_r),
    .out_stall  (out_stall),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

FILE: rtl/core/prsd_palette.sv
`default_nettype none

module prsd_palette #(
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        wr_en,
  input  wire logic [7:0]  wr_index,
  input  wire logic [23:0] wr_data,
  input  wire logic        rd_en,
  input  wire logic [7:0]  rd_index,
  output logic      [23:0] rd_data
);
  import prsd_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam logic [8:0] DEPTH_W = 9'(PALETTE_DEPTH);

  logic [23:0]              mem [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] valid_r;
  logic [23:0]              rd_q_r;
  logic                     rd_ok_r;
  logic                     wr_in_range;
  logic                     rd_in_range;

  assign wr_in_range = {1'b0, wr_index} < DEPTH_W;
  assign rd_in_range = {1'b0, rd_index} < DEPTH_W;

  always_ff @(posedge clk) begin
    if (wr_en && wr_in_range) begin
      mem[wr_index[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r  <= mem[rd_index[AW-1:0]];
      rd_ok_r <= rd_in_range && valid_r[rd_index[AW-1:0]];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en && wr_in_range) begin
      valid_r[wr_index[AW-1:0]] <= 1'b1;
    end
  end

  assign rd_data = rd_ok_r ? rd_q_r : 24'h000000;

endmodule

`default_nettype wire

FILE: rtl/core/prsd_ctrl.sv
`default_nettype none

module prsd_ctrl #(
  parameter int MAX_DIM = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire prsd_pkg::in_item_t item,
  input  wire logic              advance,
  output logic                   desc_valid,
  output prsd_pkg::desc_t        desc
);
  import prsd_pkg::*;

  localparam logic [12:0] MAX_DIM_W = 13'(MAX_DIM);

  logic [7:0]  lit_r,    lit_nxt;
  logic [23:0] bytes_r,  bytes_nxt;
  logic [23:0] done_r,   done_nxt;
  logic [23:0] limit_r,  limit_nxt;
  logic        active_r, active_nxt;
  logic        res_v;
  desc_t       res;
  logic        s1_valid_r;
  desc_t       s1_desc_r;

  logic [12:0] w_c;
  logic [12:0] h_c;
  logic [25:0] area;
  logic        dropping;
  logic        last;
  logic        pixel;
  logic        opaque;
  logic [6:0]  count;
  logic [24:0] sum;

  assign w_c  = ({1'b0, item.frame_width} > MAX_DIM_W) ? MAX_DIM_W : {1'b0, item.frame_width};
  assign h_c  = ({1'b0, item.frame_height} > MAX_DIM_W) ? MAX_DIM_W : {1'b0, item.frame_height};
  assign area = w_c * h_c;

  always_comb begin
    lit_nxt    = lit_r;
    bytes_nxt  = bytes_r;
    done_nxt   = done_r;
    limit_nxt  = limit_r;
    active_nxt = active_r;
    res_v      = 1'b0;
    res        = '{status: 1'b0, repeat_count: 7'd0, kind: KIND_NONE, frame_done: 1'b0};
    dropping   = done_r > limit_r;
    last       = 1'b0;
    pixel      = 1'b0;
    opaque     = 1'b0;
    count      = 7'd0;
    sum        = 25'd0;
    unique case (item.cmd)
      CMD_HDR: begin
        limit_nxt = area[23:0];
        bytes_nxt = item.payload_length;
        done_nxt  = 24'd0;
        lit_nxt   = 8'd0;
        if (item.payload_length == 24'd0) begin
          active_nxt     = 1'b0;
          res_v          = 1'b1;
          res.frame_done = 1'b1;
        end else begin
          active_nxt = 1'b1;
        end
      end
      CMD_DATA: begin
        if (active_r) begin
          bytes_nxt = bytes_r - 24'd1;
          last      = bytes_nxt == 24'd0;
          if (!dropping) begin
            if (lit_r != 8'd0) begin
              lit_nxt = lit_r - 8'd1;
              count   = 7'd1;
              pixel   = 1'b1;
              opaque  = 1'b1;
            end else if (item.data_byte > RUN_BASE) begin
              count = 7'(item.data_byte - RUN_BASE);
              pixel = 1'b1;
            end else begin
              lit_nxt = item.data_byte;
            end
            sum = {1'b0, done_r} + 25'(count);
            if (pixel) begin
              res_v = 1'b1;
              if (sum > {1'b0, limit_r}) begin
                // overflow: mark the frame as dropping
                done_nxt       = limit_r + 24'd1;
                res.status     = 1'b1;
                res.frame_done = 1'b1;
              end else begin
                done_nxt         = sum[23:0];
                res.repeat_count = count;
                res.kind         = opaque ? KIND_OPAQUE : KIND_CLEAR;
                res.frame_done   = last;
              end
            end else if (last) begin
              res_v          = 1'b1;
              res.frame_done = 1'b1;
            end
          end
          if (last) begin
            active_nxt = 1'b0;
            lit_nxt    = 8'd0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lit_r      <= 8'd0;
      bytes_r    <= 24'd0;
      done_r     <= 24'd0;
      limit_r    <= 24'd0;
      active_r   <= 1'b0;
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      lit_r      <= lit_nxt;
      bytes_r    <= bytes_nxt;
      done_r     <= done_nxt;
      limit_r    <= limit_nxt;
      active_r   <= active_nxt;
      s1_valid_r <= res_v;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_desc_r <= res;
    end
  end

  assign desc_valid = s1_valid_r;
  assign desc       = s1_desc_r;

endmodule

`default_nettype wire

FILE: rtl/core/prsd_out.sv
`default_nettype none

module prsd_out (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               desc_valid,
  input  wire prsd_pkg::desc_t    desc,
  input  wire logic [23:0]        rd_data,
  input  wire logic [1:0]         colour_mode,
  input  wire logic               out_stall,
  output logic                    advance,
  output logic                    out_valid,
  output prsd_pkg::out_item_t     out_item
);
  import prsd_pkg::*;

  logic      out_valid_r;
  out_item_t out_r;
  out_item_t fmt;
  logic [7:0] r;
  logic [7:0] g;
  logic [7:0] b;
  logic [7:0] a;

  always_comb begin
    unique case (desc.kind)
      KIND_OPAQUE: begin
        r = rd_data[23:16];
        g = rd_data[15:8];
        b = rd_data[7:0];
        a = OPAQUE;
      end
      KIND_CLEAR: begin
        r = 8'hFF;
        g = 8'hFF;
        b = 8'hFF;
        a = CLEAR;
      end
      default: begin
        r = 8'h00;
        g = 8'h00;
        b = 8'h00;
        a = 8'h00;
      end
    endcase
    fmt.status       = desc.status;
    fmt.repeat_count = desc.repeat_count;
    fmt.frame_done   = desc.frame_done;
    fmt.chan1        = g;
    if (colour_mode == MODE_BGRA) begin
      fmt.chan0 = b;
      fmt.chan2 = r;
      fmt.chan3 = a;
    end else begin
      fmt.chan0 = r;
      fmt.chan2 = b;
      fmt.chan3 = (colour_mode == MODE_RGB) ? CLEAR : a;
    end
  end

  assign advance = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= desc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && desc_valid) begin
      out_r <= fmt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

FILE: rtl/core/prsd_checker.sv
`default_nettype none

module prsd_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire prsd_pkg::out_item_t out_item
);
  import prsd_pkg::*;

  // a stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_ovf_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status |-> out_item.frame_done && out_item.repeat_count == 7'd0)
    else $error("overflow result must end the frame with no pixels");

  a_ovf_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status |-> out_item.chan0 == 8'd0 && out_item.chan1 == 8'd0
      && out_item.chan2 == 8'd0 && out_item.chan3 == 8'd0)
    else $error("overflow result carries channel data");

  // runs of more than one pixel are always transparent white
  a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.repeat_count > 7'd1 |-> !out_item.status
      && out_item.chan3 == CLEAR && out_item.chan1 == 8'hFF)
    else $error("run result is not transparent white");

endmodule

bind palette_rle_sprite_decoder prsd_checker u_prsd_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_item (out_item)
);

`default_nettype wire
